// File: hw/rtl/mrpct_pkg.sv
// ----------------------------------------------------------------------------
// mrpct_pkg
// Shared types and constants for the raster to page-column transposer.
// ----------------------------------------------------------------------------
package mrpct_pkg;

  localparam int PIX_W          = 8;
  localparam int BPL_W          = 5;
  localparam int BANDS_W        = 4;
  localparam int CFG_DATA_W     = 5;
  localparam int CNT_W          = 7;
  localparam int STORE_ROWS     = 7;
  localparam int BPL_DEFAULT    = 16;
  localparam int BANDS_DEFAULT  = 8;
  localparam int MAX_LINE_BYTES = 16;
  localparam int MAX_BANDS      = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam int QCNT_W         = 3;

  localparam logic [2:0] LAST_ROW = 3'd7;
  localparam logic [2:0] LAST_IDX = 3'd7;

  localparam logic REG_BYTES_PER_LINE = 1'b0;
  localparam logic REG_BAND_COUNT     = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [7:0][PIX_W-1:0] pages;
    logic                  frame_end;
  } page_entry_t;

  function automatic logic [CNT_W-1:0] clamp_cfg(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] res;
    if (v == '0) begin
      res = CNT_W'(1);
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/mrpct_ram.sv
// ----------------------------------------------------------------------------
// mrpct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/mrpct_front.sv
// ----------------------------------------------------------------------------
// mrpct_front
// Tracks the raster position, stores rows 0 to 6 of the band and, for each
// row 7 item, transposes the 8x8 bit block into a queue entry.
// ----------------------------------------------------------------------------
module mrpct_front #(
  parameter int MAX_LINE_BYTES = mrpct_pkg::MAX_LINE_BYTES,
  parameter int MAX_BANDS      = mrpct_pkg::MAX_BANDS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mrpct_pkg::PIX_W-1:0]        in_pixel_byte,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [mrpct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [mrpct_pkg::QCNT_W-1:0]       q_count,
  output logic                               push,
  output mrpct_pkg::page_entry_t             push_entry
);

  localparam int COL_W  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int BAND_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam logic [mrpct_pkg::BPL_W-1:0] BPL_RST =
    (MAX_LINE_BYTES < mrpct_pkg::BPL_DEFAULT) ? mrpct_pkg::BPL_W'(MAX_LINE_BYTES)
                                              : mrpct_pkg::BPL_W'(mrpct_pkg::BPL_DEFAULT);
  localparam logic [mrpct_pkg::BANDS_W-1:0] BANDS_RST =
    (MAX_BANDS < mrpct_pkg::BANDS_DEFAULT) ? mrpct_pkg::BANDS_W'(MAX_BANDS)
                                           : mrpct_pkg::BANDS_W'(mrpct_pkg::BANDS_DEFAULT);

  logic [COL_W-1:0]                   col_r, col_nxt;
  logic [2:0]                         row_r, row_nxt;
  logic [BAND_W-1:0]                  band_r, band_nxt;
  logic [mrpct_pkg::BPL_W-1:0]        bpl_r, bpl_nxt;
  logic [mrpct_pkg::BANDS_W-1:0]      bands_r, bands_nxt;
  logic                               s1_valid_r, s1_valid_nxt;
  logic [mrpct_pkg::PIX_W-1:0]        s1_pix_r;
  logic                               s1_fe_r;

  logic                               accept;
  logic                               line_end;
  logic                               last_band;
  logic [mrpct_pkg::CNT_W-1:0]        col_inc;
  logic [mrpct_pkg::CNT_W-1:0]        band_inc;
  logic [mrpct_pkg::CNT_W-1:0]        bpl_clamped;
  logic [mrpct_pkg::CNT_W-1:0]        bands_clamped;
  logic [mrpct_pkg::QCNT_W:0]         q_used;
  logic [mrpct_pkg::PIX_W-1:0]        rows [8];

  assign q_used   = {1'b0, q_count} + {{mrpct_pkg::QCNT_W{1'b0}}, s1_valid_r};
  assign in_ready = (q_used < (mrpct_pkg::QCNT_W + 1)'(mrpct_pkg::QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  assign col_inc   = mrpct_pkg::CNT_W'(col_r) + mrpct_pkg::CNT_W'(1);
  assign band_inc  = mrpct_pkg::CNT_W'(band_r) + mrpct_pkg::CNT_W'(1);
  assign line_end  = (col_inc >= mrpct_pkg::CNT_W'(bpl_r));
  assign last_band = (band_inc >= mrpct_pkg::CNT_W'(bands_r));

  assign bpl_clamped   = mrpct_pkg::clamp_cfg(mrpct_pkg::CNT_W'(cfg_wdata),
                                              mrpct_pkg::CNT_W'(MAX_LINE_BYTES));
  assign bands_clamped = mrpct_pkg::clamp_cfg(
                           mrpct_pkg::CNT_W'(cfg_wdata[mrpct_pkg::BANDS_W-1:0]),
                           mrpct_pkg::CNT_W'(MAX_BANDS));

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    band_nxt     = band_r;
    bpl_nxt      = bpl_r;
    bands_nxt    = bands_r;
    s1_valid_nxt = accept && (row_r == mrpct_pkg::LAST_ROW);
    if (cfg_we) begin
      case (cfg_index)
        mrpct_pkg::REG_BYTES_PER_LINE: begin
          bpl_nxt = bpl_clamped[mrpct_pkg::BPL_W-1:0];
        end
        mrpct_pkg::REG_BAND_COUNT: begin
          bands_nxt = bands_clamped[mrpct_pkg::BANDS_W-1:0];
        end
        default: begin
          bpl_nxt = bpl_r;
        end
      endcase
      col_nxt  = '0;
      row_nxt  = '0;
      band_nxt = '0;
    end else if (accept) begin
      if (line_end) begin
        col_nxt = '0;
        if (row_r == mrpct_pkg::LAST_ROW) begin
          row_nxt  = '0;
          band_nxt = last_band ? '0 : band_inc[BAND_W-1:0];
        end else begin
          row_nxt = row_r + 3'd1;
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      band_r     <= '0;
      bpl_r      <= BPL_RST;
      bands_r    <= BANDS_RST;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      band_r     <= band_nxt;
      bpl_r      <= bpl_nxt;
      bands_r    <= bands_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r <= in_pixel_byte;
      s1_fe_r  <= line_end && last_band;
    end
  end

  for (genvar r = 0; r < mrpct_pkg::STORE_ROWS; r++) begin : g_row
    mrpct_ram #(
      .WIDTH (mrpct_pkg::PIX_W),
      .DEPTH (MAX_LINE_BYTES)
    ) u_row_ram (
      .clk     (clk),
      .wr_en   (accept && (row_r == 3'(r))),
      .wr_addr (col_r),
      .wr_data (in_pixel_byte),
      .rd_en   (accept),
      .rd_addr (col_r),
      .rd_data (rows[r])
    );
  end

  assign rows[mrpct_pkg::STORE_ROWS] = s1_pix_r;

  always_comb begin
    push_entry.frame_end = s1_fe_r;
    for (int b = 0; b < 8; b++) begin
      for (int r = 0; r < 8; r++) begin
        push_entry.pages[b][r] = rows[r][7-b];
      end
    end
  end

  assign push = s1_valid_r;

endmodule

// File: hw/rtl/mrpct_queue.sv
// ----------------------------------------------------------------------------
// mrpct_queue
// Short queue of transposed blocks between the front and back parts.
// ----------------------------------------------------------------------------
module mrpct_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  mrpct_pkg::page_entry_t        push_entry,
  input  logic                          pop,
  output logic                          head_valid,
  output mrpct_pkg::page_entry_t        head_entry,
  output logic [mrpct_pkg::QCNT_W-1:0]  count
);

  mrpct_pkg::page_entry_t              slot_r [mrpct_pkg::QUEUE_DEPTH];
  logic [mrpct_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [mrpct_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [mrpct_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                                do_pop;

  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hw/rtl/mrpct_back.sv
// ----------------------------------------------------------------------------
// mrpct_back
// Takes one transposed block from the queue and sends its eight page bytes,
// one item per cycle while out_ready is high, with the run-end and frame-end flags.
// ----------------------------------------------------------------------------
module mrpct_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  mrpct_pkg::page_entry_t        head_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mrpct_pkg::PIX_W-1:0]   out_page_byte,
  output logic                          out_last_of_run,
  output logic                          out_last_of_frame
);

  logic                     busy_r, busy_nxt;
  logic [2:0]               idx_r, idx_nxt;
  mrpct_pkg::page_entry_t   ent_r, ent_nxt;
  logic                     run_end;

  assign run_end = (idx_r == mrpct_pkg::LAST_IDX);
  assign pop     = head_valid && (!busy_r || (out_ready && run_end));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    ent_nxt  = ent_r;
    if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      ent_nxt  = head_entry;
    end else if (busy_r && out_ready) begin
      if (run_end) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign out_valid         = busy_r;
  assign out_page_byte     = ent_r.pages[idx_r];
  assign out_last_of_run   = run_end;
  assign out_last_of_frame = run_end && ent_r.frame_end;

endmodule

// File: hw/rtl/mono_raster_to_page_column_transpose.sv
// ----------------------------------------------------------------------------
// mono_raster_to_page_column_transpose
// Turns a row-major 1-bit raster into page bytes of eight vertical pixels.
// ----------------------------------------------------------------------------
// Items of rows 0 to 6 produce no output and go in one per cycle while ready.
// A row 7 item passes the front stage register, the block queue and the back
// part's entry register; its block then gives eight page bytes in all.
// The back part sends one page byte per cycle while out_ready is high; a
// four-entry queue of blocks lets the input run on while those bytes go out.
// Reset clears the position and the queue and sets both registers to their
// defaults; the band store is not cleared and needs no clearing pass.
module mono_raster_to_page_column_transpose #(
  parameter int MAX_LINE_BYTES = mrpct_pkg::MAX_LINE_BYTES,
  parameter int MAX_BANDS      = mrpct_pkg::MAX_BANDS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mrpct_pkg::PIX_W-1:0]       in_pixel_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mrpct_pkg::PIX_W-1:0]       out_page_byte,
  output logic                              out_last_of_run,
  output logic                              out_last_of_frame,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [mrpct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                             push;
  mrpct_pkg::page_entry_t           push_entry;
  logic                             pop;
  logic                             head_valid;
  mrpct_pkg::page_entry_t           head_entry;
  logic [mrpct_pkg::QCNT_W-1:0]     q_count;

  mrpct_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_BANDS      (MAX_BANDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_byte (in_pixel_byte),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .q_count       (q_count),
    .push          (push),
    .push_entry    (push_entry)
  );

  mrpct_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .count      (q_count)
  );

  mrpct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_entry        (head_entry),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_page_byte     (out_page_byte),
    .out_last_of_run   (out_last_of_run),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule
